// ===== src/top_off_pump_alarm_controller_top_defines.svh =====
// Assertion macros used by the top-off controller checker.
`ifndef TOP_OFF_PUMP_ALARM_CONTROLLER_TOP_DEFINES_SVH
`define TOP_OFF_PUMP_ALARM_CONTROLLER_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TOPOFF_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define TOPOFF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/topoff_pkg.sv =====
// Types, register indexes and helpers for the top-off pump alarm controller.
package topoff_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MINUTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ON_SECONDS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_SECONDS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PUMP_ALARM_MINUTES = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_INVERT         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_INVERT        = 3'd5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic        high_invert;
    logic        low_invert;
    logic [15:0] pump_alarm_minutes;
    logic [15:0] debounce_seconds;
    logic [15:0] max_on_seconds;
    logic [15:0] alarm_minutes;
  } cfg_t;

  typedef struct packed {
    logic        force_on;
    logic        enabled;
    logic        high_switch_level;
    logic        low_switch_level;
    logic [31:0] epoch_seconds;
  } item_t;

  typedef struct packed {
    logic pump_alarm;
    logic high_alarm;
    logic low_alarm;
    logic pump_on;
  } result_t;

  // Minutes to seconds as (m * 64) - (m * 4).
  function automatic logic [21:0] minutes_to_seconds(input logic [15:0] minutes);
    minutes_to_seconds = {minutes, 6'b0} - {4'b0, minutes, 2'b0};
  endfunction

endpackage

// ===== src/top_off_pump_alarm_controller_top.sv =====
// Top level of the top-off pump alarm controller.
//
//   Channel  Direction  Contents
//   s_*      in         one tick: epoch seconds, float levels, enable, force-on
//   m_*      out        one result beat per tick: pump and alarm flags
//   cfg_*    in         register writes, no read-back
//
// A tick is taken into an input register at its accept edge, evaluated
// combinationally and written to the output register when the output can
// advance. One beat can be accepted every cycle while the output is not stalled;
// the limit is the single evaluation stage.
// Reset is synchronous and returns the flags and configuration registers to their
// defaults; the timestamps are loaded before they are used.
// A stalled output holds its beat while the input register still takes one more.
module top_off_pump_alarm_controller_top
  import topoff_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // epoch_seconds[31:0], low_switch_level[32], high_switch_level[33],
  // enabled[34], force_on[35], zero fill[39:36]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pump_on[0], low_alarm[1], high_alarm[2], pump_alarm[3], zero fill[7:4]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t out_result;
  logic    out_valid;
  result_t result;
  logic    advance;
  logic    step;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !rst && (!in_valid || advance);
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_minutes      <= 16'd60;
      cfg.max_on_seconds     <= 16'd30;
      cfg.debounce_seconds   <= 16'd3;
      cfg.pump_alarm_minutes <= 16'd60;
      cfg.low_invert         <= 1'b0;
      cfg.high_invert        <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALARM_MINUTES:      cfg.alarm_minutes      <= cfg_wdata;
        REG_MAX_ON_SECONDS:     cfg.max_on_seconds     <= cfg_wdata;
        REG_DEBOUNCE_SECONDS:   cfg.debounce_seconds   <= cfg_wdata;
        REG_PUMP_ALARM_MINUTES: cfg.pump_alarm_minutes <= cfg_wdata;
        REG_LOW_INVERT:         cfg.low_invert         <= cfg_wdata[0];
        REG_HIGH_INVERT:        cfg.high_invert        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= item_t'(s_tdata[35:0]);
    end
    if (step) begin
      out_result <= result;
    end
  end

  topoff_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

endmodule

// ===== src/topoff_core.sv =====
// Controller state and the per-tick evaluation of alarms and pump drive.
module topoff_core
  import topoff_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic        low_valid;
  logic [31:0] low_since;
  logic        pump_alarm_flag;
  logic [31:0] pump_alarm_since;
  logic        pump_running;
  logic [31:0] pump_started_at;

  logic        low_valid_next;
  logic [31:0] low_since_next;
  logic        pump_alarm_flag_next;
  logic [31:0] pump_alarm_since_next;
  logic        pump_running_next;
  logic [31:0] pump_started_at_next;

  logic [32:0] t_wide;
  logic [32:0] pump_alarm_limit;
  logic [32:0] debounce_limit;
  logic [32:0] low_alarm_limit;
  logic [32:0] run_limit;
  logic        alarm_kept;
  logic        lo_flag;
  logic        hi_flag;
  logic        water_lo;
  logic        low_alarm;
  logic        run_over;

  always_comb begin
    t_wide = {1'b0, item.epoch_seconds};

    pump_alarm_limit = {1'b0, pump_alarm_since}
                     + {11'b0, minutes_to_seconds(cfg.pump_alarm_minutes)};
    alarm_kept = pump_alarm_flag && !(t_wide > pump_alarm_limit);

    lo_flag = (!item.low_switch_level) ^ cfg.low_invert;
    low_valid_next = lo_flag;
    low_since_next = (lo_flag && !low_valid) ? item.epoch_seconds : low_since;

    debounce_limit  = {1'b0, low_since_next} + {17'b0, cfg.debounce_seconds};
    low_alarm_limit = {1'b0, low_since_next}
                    + {11'b0, minutes_to_seconds(cfg.alarm_minutes)};
    water_lo  = lo_flag && !(t_wide < debounce_limit);
    low_alarm = water_lo && (t_wide > low_alarm_limit);

    hi_flag = (!item.high_switch_level) ^ cfg.high_invert;

    run_limit = {1'b0, pump_started_at} + {17'b0, cfg.max_on_seconds};
    run_over  = pump_running && (t_wide > run_limit);
    pump_alarm_flag_next  = alarm_kept || run_over;
    pump_alarm_since_next = (pump_alarm_flag_next && !alarm_kept) ?
                            item.epoch_seconds : pump_alarm_since;

    pump_running_next = !hi_flag &&
                        (item.force_on ||
                         (water_lo && !pump_alarm_flag_next && item.enabled));
    pump_started_at_next = (pump_running_next && !pump_running) ?
                           item.epoch_seconds : pump_started_at;

    result.pump_on    = pump_running_next;
    result.low_alarm  = low_alarm;
    result.high_alarm = hi_flag;
    result.pump_alarm = pump_alarm_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_valid       <= 1'b0;
      pump_alarm_flag <= 1'b0;
      pump_running    <= 1'b0;
    end else if (step) begin
      low_valid       <= low_valid_next;
      pump_alarm_flag <= pump_alarm_flag_next;
      pump_running    <= pump_running_next;
    end
  end

  // Timestamps are only read while their flag is set, so they need no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      low_since        <= low_since_next;
      pump_alarm_since <= pump_alarm_since_next;
      pump_started_at  <= pump_started_at_next;
    end
  end

endmodule

// ===== src/topoff_checker.sv =====
// Port-level checks for the top-off pump alarm controller, bound to the top level.
`include "top_off_pump_alarm_controller_top_defines.svh"

module topoff_checker
  import topoff_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `TOPOFF_ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !m_tvalid, "output valid after reset")
  `TOPOFF_ASSERT_ALWAYS(a_pump_off_high, clk, rst, !(m_tvalid && m_tdata[0] && m_tdata[2]), "pump on with high alarm")
  `TOPOFF_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
  `TOPOFF_ASSERT_ALWAYS(a_result_has_tick, clk, rst, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without a tick")

endmodule

bind top_off_pump_alarm_controller_top topoff_checker u_topoff_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
